[rtl/core/b64d_pkg.sv]
package b64d_pkg;

    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;
    localparam logic [6:0] SEXTET_BAD = 7'd64;

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    typedef struct packed {
        logic [7:0] char_in;
        logic       char_last;
    } in_word_t;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        byte_valid;
        logic        last_of_run;
        logic        stream_end;
        logic [15:0] byte_total;
    } out_word_t;

    // one accepted character worth of results, up to three words
    typedef struct packed {
        logic [1:0]      count;
        out_word_t [2:0] res;
    } job_t;

    // 0..63 for alphabet characters, bit 6 set otherwise
    function automatic logic [6:0] map_char(input logic [7:0] c);
        logic [6:0] s;
        s = SEXTET_BAD;
        if (c >= 8'h41 && c <= 8'h5A) s = 7'(c - 8'h41);
        else if (c >= 8'h61 && c <= 8'h7A) s = 7'(c - 8'h61 + 8'd26);
        else if (c >= 8'h30 && c <= 8'h39) s = 7'(c - 8'h30 + 8'd52);
        else if (c == CHAR_PLUS) s = 7'd62;
        else if (c == CHAR_SLASH) s = 7'd63;
        return s;
    endfunction

    function automatic logic [7:0] pack_first(input logic [5:0] a, input logic [5:0] b);
        return {a, b[5:4]};
    endfunction

    function automatic logic [7:0] pack_second(input logic [5:0] b, input logic [5:0] d);
        return {b[3:0], d[5:2]};
    endfunction

    function automatic logic [7:0] pack_third(input logic [5:0] d, input logic [5:0] s);
        return {d[1:0], s};
    endfunction

endpackage

[rtl/core/base64_stream_decoder_top.sv]
// Streaming Base64 decoder. One character word is taken per cycle on the in channel, with
// char_last on the final character of a string; decoded bytes leave one word per cycle on the
// out channel while out_ready is high, byte_total counting the bytes delivered so far and
// saturating at limit_reg (write it through cfg_we/cfg_wdata while idle). The first '=' or
// non-alphabet character stops decoding until the final character, which flushes a partial
// group of 2 or 3 characters into 1 or 2 bytes and always closes the string with a word marked
// stream_end (a marker word with byte_valid low if no byte goes out). The character side keeps
// one word per cycle as long as the 4-entry queue between the decode front and the output
// serializer has room; a complete group gives 3 output words for every 4 characters, so the
// single output register keeps pace while out_ready is high and a long run of text goes in at
// one character per cycle. When nothing is queued, the first word of a character is written
// into the queue and then into the output register.
module base64_stream_decoder_top (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [15:0]         cfg_wdata,
    input  logic                in_valid,
    output logic                in_ready,
    input  b64d_pkg::in_word_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output b64d_pkg::out_word_t out_data
);

    logic           q_full;
    logic           q_push;
    logic           q_pop;
    logic           head_valid;
    b64d_pkg::job_t push_job;
    b64d_pkg::job_t head_job;

    b64d_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_job     (push_job)
    );

    b64d_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_job   (push_job),
        .pop        (q_pop),
        .full       (q_full),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    b64d_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (q_pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

endmodule

[rtl/core/b64d_front.sv]
module b64d_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [15:0]        cfg_wdata,
    input  logic               in_valid,
    output logic               in_ready,
    input  b64d_pkg::in_word_t in_data,
    input  logic               q_full,
    output logic               q_push,
    output b64d_pkg::job_t     q_job
);

    logic [15:0] limit_reg;
    logic [5:0]  store_reg [3];
    logic [5:0]  store_next [3];
    logic [1:0]  fill_reg, fill_next;
    logic        halted_reg, halted_next;
    logic [15:0] sent_reg, sent_next;

    logic [6:0]  sx;
    logic [7:0]  cand [3];
    logic [1:0]  cand_n;
    logic [15:0] avail;
    logic [1:0]  n;
    logic        accept;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        sx          = b64d_pkg::map_char(in_data.char_in);
        store_next  = store_reg;
        fill_next   = fill_reg;
        halted_next = halted_reg;
        cand[0]     = '0;
        cand[1]     = '0;
        cand[2]     = '0;
        cand_n      = 2'd0;

        if (!halted_reg)
        begin
            if (sx[6])
            begin
                halted_next = 1'b1;
            end
            else if (fill_reg != 2'd3)
            begin
                store_next[fill_reg] = sx[5:0];
                fill_next            = fill_reg + 2'd1;
            end
            else
            begin
                cand[0]   = b64d_pkg::pack_first(store_reg[0], store_reg[1]);
                cand[1]   = b64d_pkg::pack_second(store_reg[1], store_reg[2]);
                cand[2]   = b64d_pkg::pack_third(store_reg[2], sx[5:0]);
                cand_n    = 2'd3;
                fill_next = 2'd0;
            end
        end

        // trailing partial group flush
        if (in_data.char_last)
        begin
            if (fill_next >= 2'd2)
            begin
                cand[0] = b64d_pkg::pack_first(store_next[0], store_next[1]);
                cand_n  = 2'd1;
            end
            if (fill_next == 2'd3)
            begin
                cand[1] = b64d_pkg::pack_second(store_next[1], store_next[2]);
                cand_n  = 2'd2;
            end
        end

        avail = (limit_reg > sent_reg) ? (limit_reg - sent_reg) : 16'd0;
        n     = (avail < {14'd0, cand_n}) ? avail[1:0] : cand_n;

        for (int i = 0; i < 3; i++)
        begin
            q_job.res[i].out_byte    = cand[i];
            q_job.res[i].byte_valid  = 1'b1;
            q_job.res[i].byte_total  = sent_reg + 16'(i + 1);
            q_job.res[i].last_of_run = (2'(i) == n - 2'd1);
            q_job.res[i].stream_end  = in_data.char_last && (2'(i) == n - 2'd1);
        end
        q_job.count = n;

        // final character with nothing delivered gets a marker word
        if (in_data.char_last && n == 2'd0)
        begin
            q_job.res[0].out_byte    = 8'd0;
            q_job.res[0].byte_valid  = 1'b0;
            q_job.res[0].byte_total  = sent_reg;
            q_job.res[0].last_of_run = 1'b1;
            q_job.res[0].stream_end  = 1'b1;
            q_job.count              = 2'd1;
        end

        sent_next = sent_reg + {14'd0, n};
        if (in_data.char_last)
        begin
            store_next[0] = '0;
            store_next[1] = '0;
            store_next[2] = '0;
            fill_next     = 2'd0;
            halted_next   = 1'b0;
            sent_next     = 16'd0;
        end

        q_push = accept && (q_job.count != 2'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg    <= 16'hFFFF;
            store_reg[0] <= '0;
            store_reg[1] <= '0;
            store_reg[2] <= '0;
            fill_reg     <= 2'd0;
            halted_reg   <= 1'b0;
            sent_reg     <= 16'd0;
        end
        else
        begin
            if (cfg_we)
            begin
                limit_reg <= cfg_wdata;
            end
            if (accept)
            begin
                store_reg  <= store_next;
                fill_reg   <= fill_next;
                halted_reg <= halted_next;
                sent_reg   <= sent_next;
            end
        end
    end

endmodule

[rtl/core/b64d_queue.sv]
module b64d_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  b64d_pkg::job_t push_job,
    input  logic           pop,
    output logic           full,
    output logic           head_valid,
    output b64d_pkg::job_t head_job
);

    b64d_pkg::job_t          mem [b64d_pkg::QDEPTH];
    logic [b64d_pkg::QAW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [b64d_pkg::QAW:0]   count_reg;

    assign full       = (count_reg == (b64d_pkg::QAW+1)'(b64d_pkg::QDEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

[rtl/core/b64d_back.sv]
module b64d_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                head_valid,
    input  b64d_pkg::job_t      head_job,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_ready,
    output b64d_pkg::out_word_t out_data
);

    logic [1:0]          pos_reg, pos_next;
    logic                valid_reg, valid_next;
    b64d_pkg::out_word_t data_reg, data_next;
    logic                load;

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb
    begin
        load       = head_valid && (!valid_reg || out_ready);
        pos_next   = pos_reg;
        valid_next = valid_reg && !out_ready;
        data_next  = data_reg;
        pop        = 1'b0;
        if (load)
        begin
            data_next  = head_job.res[pos_reg];
            valid_next = 1'b1;
            // step through the words of the head entry, retire it on the last one
            if (pos_reg == head_job.count - 2'd1)
            begin
                pos_next = 2'd0;
                pop      = 1'b1;
            end
            else
            begin
                pos_next = pos_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= 2'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg   <= pos_next;
            valid_reg <= valid_next;
        end
    end

endmodule

[test/base64_stream_decoder_top_tb.sv]
module base64_stream_decoder_top_tb;

    localparam int         WD_LIMIT    = 2000;
    localparam int         HOLD_CYCLES = 80;
    localparam int         SETTLE      = 8;
    localparam int         PHASES      = 7;
    localparam int         PHASE_CHARS = 58;
    localparam logic [7:0] CHAR_PAD    = 8'h3D;

    // how the expectation of a directed row is formed
    typedef enum logic [1:0] {
        ROW_PRED,
        ROW_NONE,
        ROW_MARK,
        ROW_GROUP
    } row_kind_e;

    typedef struct packed {
        logic [7:0]  ch;
        logic        lst;
        row_kind_e   kind;
        logic [23:0] bytes;
        logic [15:0] total;
    } dir_row_t;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                cfg_we;
    logic [15:0]         cfg_wdata;
    logic                in_valid;
    logic                in_ready;
    b64d_pkg::in_word_t  in_data;
    logic                out_valid;
    logic                out_ready;
    b64d_pkg::out_word_t out_data;

    base64_stream_decoder_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // decoder state as the testbench sees it
    logic [5:0]  sx [3] = '{6'd0, 6'd0, 6'd0};
    logic [1:0]  fill   = 2'd0;
    logic        halt   = 1'b0;
    logic [15:0] sent   = 16'd0;
    logic [15:0] limit_q = 16'hFFFF;

    b64d_pkg::out_word_t fresh [$];
    b64d_pkg::out_word_t byte_q [$];
    b64d_pkg::out_word_t want;

    int   errors      = 0;
    int   idle_cycles = 0;
    int   chars_sent  = 0;
    bit   quiet       = 1'b0;
    bit   hold_req    = 1'b0;
    bit   rx_busy     = 1'b1;
    bit   tx_gappy    = 1'b1;
    logic [15:0] limit_plan [PHASES];

    dir_row_t dir_tab [24] = '{
        '{"=",   1'b1, ROW_MARK,  24'h0,      16'd0},
        '{"T",   1'b0, ROW_NONE,  24'h0,      16'd0},
        '{"W",   1'b0, ROW_NONE,  24'h0,      16'd0},
        '{"F",   1'b0, ROW_NONE,  24'h0,      16'd0},
        '{"u",   1'b0, ROW_GROUP, 24'h4D616E, 16'd1},
        '{"/",   1'b0, ROW_NONE,  24'h0,      16'd0},
        '{"/",   1'b0, ROW_NONE,  24'h0,      16'd0},
        '{"/",   1'b0, ROW_NONE,  24'h0,      16'd0},
        '{"/",   1'b0, ROW_GROUP, 24'hFFFFFF, 16'd4},
        '{"z",   1'b0, ROW_PRED,  24'h0,      16'd0},
        '{"9",   1'b0, ROW_PRED,  24'h0,      16'd0},
        '{"0",   1'b0, ROW_PRED,  24'h0,      16'd0},
        '{"A",   1'b0, ROW_PRED,  24'h0,      16'd0},
        '{"+",   1'b0, ROW_PRED,  24'h0,      16'd0},
        '{"Z",   1'b1, ROW_PRED,  24'h0,      16'd0},
        '{"A",   1'b0, ROW_PRED,  24'h0,      16'd0},
        '{"a",   1'b0, ROW_PRED,  24'h0,      16'd0},
        '{"+",   1'b0, ROW_PRED,  24'h0,      16'd0},
        '{8'h00, 1'b0, ROW_PRED,  24'h0,      16'd0},
        '{"Q",   1'b0, ROW_PRED,  24'h0,      16'd0},
        '{8'h80, 1'b1, ROW_PRED,  24'h0,      16'd0},
        '{8'h7F, 1'b1, ROW_MARK,  24'h0,      16'd0},
        '{8'hFF, 1'b1, ROW_MARK,  24'h0,      16'd0},
        '{"A",   1'b1, ROW_MARK,  24'h0,      16'd0}
    };

    // bit 6 set for anything outside the alphabet
    function automatic logic [6:0] sextet_of(input logic [7:0] c);
        if (c >= "a" && c <= "z")
            return 7'(c - "a" + 8'd26);
        if (c >= "A" && c <= "Z")
            return 7'(c - "A");
        if (c >= "0" && c <= "9")
            return 7'(c - "0" + 8'd52);
        if (c == b64d_pkg::CHAR_SLASH)
            return 7'd63;
        if (c == b64d_pkg::CHAR_PLUS)
            return 7'd62;
        return 7'h40;
    endfunction

    function automatic void offer_byte(input logic [7:0] b);
        b64d_pkg::out_word_t w;
        if (sent < limit_q)
        begin
            sent = sent + 16'd1;
            w = '0;
            w.out_byte = b;
            w.byte_valid = 1'b1;
            w.byte_total = sent;
            fresh.push_back(w);
        end
    endfunction

    // fills fresh with the words one accepted character gives
    function automatic void decode_char(input logic [7:0] ch, input logic lst);
        logic [6:0]          s;
        b64d_pkg::out_word_t w;
        fresh.delete();
        if (!halt)
        begin
            s = sextet_of(ch);
            if (s[6])
                halt = 1'b1;
            else if (fill != 2'd3)
            begin
                sx[fill] = s[5:0];
                fill = fill + 2'd1;
            end
            else
            begin
                offer_byte({sx[0], sx[1][5:4]});
                offer_byte({sx[1][3:0], sx[2][5:2]});
                offer_byte({sx[2][1:0], s[5:0]});
                fill = 2'd0;
            end
        end
        if (lst)
        begin
            if (fill >= 2'd2)
                offer_byte({sx[0], sx[1][5:4]});
            if (fill == 2'd3)
                offer_byte({sx[1][3:0], sx[2][5:2]});
            if (fresh.size() == 0)
            begin
                w = '0;
                w.byte_total = sent;
                fresh.push_back(w);
            end
            w = fresh.pop_back();
            w.stream_end = 1'b1;
            fresh.push_back(w);
            sx = '{6'd0, 6'd0, 6'd0};
            fill = 2'd0;
            halt = 1'b0;
            sent = 16'd0;
        end
        if (fresh.size() != 0)
        begin
            w = fresh.pop_back();
            w.last_of_run = 1'b1;
            fresh.push_back(w);
        end
    endfunction

    function automatic b64d_pkg::out_word_t typed_word(input logic [7:0] b, input logic v,
                                                       input logic lr, input logic se,
                                                       input logic [15:0] total);
        b64d_pkg::out_word_t w;
        w.out_byte = b;
        w.byte_valid = v;
        w.last_of_run = lr;
        w.stream_end = se;
        w.byte_total = total;
        return w;
    endfunction

    function automatic logic [7:0] rand_b64();
        int idx;
        idx = $urandom_range(0, 63);
        if (idx < 26)
            return 8'("A" + idx);
        if (idx < 52)
            return 8'("a" + idx - 26);
        if (idx < 62)
            return 8'("0" + idx - 52);
        return (idx == 62) ? b64d_pkg::CHAR_PLUS : b64d_pkg::CHAR_SLASH;
    endfunction

    function automatic logic [7:0] bad_char();
        logic [7:0] c;
        logic [6:0] s;
        if ($urandom_range(0, 1) == 0)
            return CHAR_PAD;
        c = 8'($urandom_range(0, 255));
        s = sextet_of(c);
        while (!s[6])
        begin
            c = 8'($urandom_range(0, 255));
            s = sextet_of(c);
        end
        return c;
    endfunction

    function automatic void check_field(input string name, input logic [15:0] exp_v,
                                        input logic [15:0] got_v);
        if (exp_v !== got_v)
        begin
            $error("%s: expected %0h, got %0h", name, exp_v, got_v);
            errors++;
        end
    endfunction

    // called at a falling edge, returns at a falling edge
    task automatic send_char(input logic [7:0] ch, input logic lst, input row_kind_e kind,
                             input logic [23:0] bytes, input logic [15:0] total);
        if (!quiet && tx_gappy && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clk);
        end
        in_data.char_in <= ch;
        in_data.char_last <= lst;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        decode_char(ch, lst);
        case (kind)
            ROW_PRED:
                foreach (fresh[i])
                    byte_q.push_back(fresh[i]);
            ROW_MARK:
                byte_q.push_back(typed_word(8'h00, 1'b0, 1'b1, 1'b1, total));
            ROW_GROUP:
            begin
                byte_q.push_back(typed_word(bytes[23:16], 1'b1, 1'b0, 1'b0, total));
                byte_q.push_back(typed_word(bytes[15:8], 1'b1, 1'b0, 1'b0, total + 16'd1));
                byte_q.push_back(typed_word(bytes[7:0], 1'b1, 1'b1, lst, total + 16'd2));
            end
            default:
                ;
        endcase
        chars_sent++;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (byte_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic set_limit(input logic [15:0] v);
        cfg_wdata <= v;
        cfg_we <= 1'b1;
        @(negedge clk);
        cfg_we <= 1'b0;
        limit_q = v;
    endtask

    // mostly well-formed strings, some noise and some broken by a stray character
    task automatic send_string();
        logic [7:0] txt [$];
        int kind;
        int n;
        int pos;
        kind = $urandom_range(0, 9);
        tx_gappy = ($urandom_range(0, 3) != 0);
        if (kind <= 6)
        begin
            n = 4 * $urandom_range(0, 3) + $urandom_range(0, 3);
            repeat (n) txt.push_back(rand_b64());
            if (n % 4 >= 2 && $urandom_range(0, 1) == 1)
                repeat (4 - n % 4) txt.push_back(CHAR_PAD);
        end
        else if (kind == 7)
        begin
            repeat ($urandom_range(1, 8)) txt.push_back(8'($urandom_range(0, 255)));
        end
        else if (kind == 8)
        begin
            n = $urandom_range(2, 12);
            pos = $urandom_range(0, n - 1);
            for (int i = 0; i < n; i++)
                txt.push_back(i == pos ? bad_char() : rand_b64());
        end
        if (txt.size() == 0)
            txt.push_back(8'($urandom_range(0, 255)));
        foreach (txt[i])
            send_char(txt[i], i == txt.size() - 1, ROW_PRED, 24'h0, 16'd0);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (byte_q.size() == 0)
            begin
                $error("word with nothing expected: out_byte %0h total %0d",
                       out_data.out_byte, out_data.byte_total);
                errors++;
            end
            else
            begin
                want = byte_q.pop_front();
                check_field("out_byte", 16'(want.out_byte), 16'(out_data.out_byte));
                check_field("byte_valid", 16'(want.byte_valid), 16'(out_data.byte_valid));
                check_field("last_of_run", 16'(want.last_of_run), 16'(out_data.last_of_run));
                check_field("stream_end", 16'(want.stream_end), 16'(out_data.stream_end));
                check_field("byte_total", want.byte_total, out_data.byte_total);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WD_LIMIT)
            begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // receiver: random stalls in bursts, one long hold-off on request
    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if ($urandom_range(0, 39) == 0)
                rx_busy = !rx_busy;
            if (hold_req)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
                out_ready <= 1'b1;
            end
            else if (!quiet && rx_busy && $urandom_range(0, 4) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(negedge clk);
                out_ready <= 1'b1;
            end
            else
                out_ready <= 1'b1;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        in_valid = 1'b0;
        in_data = '0;
        limit_plan = '{16'hFFFF, 16'd0, 16'd1, 16'd4, 16'hFFFF, 16'd9, 16'hFFFF};
        limit_plan[5] = 16'($urandom_range(2, 40));
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (dir_tab[i])
            send_char(dir_tab[i].ch, dir_tab[i].lst, dir_tab[i].kind,
                      dir_tab[i].bytes, dir_tab[i].total);
        wait_drained();

        for (int p = 0; p < PHASES; p++)
        begin
            if (p == PHASES - 1)
                quiet = 1'b1;
            set_limit(limit_plan[p]);
            if (p == 4)
                hold_req = 1'b1;
            chars_sent = 0;
            while (chars_sent < PHASE_CHARS)
            begin
                send_string();
                // sender stops mid-phase until every word is out
                if (p == 2 && chars_sent >= PHASE_CHARS / 2 && chars_sent < PHASE_CHARS / 2 + 8)
                    wait_drained();
            end
            wait_drained();
        end

        repeat (SETTLE) @(negedge clk);
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
